@@ src/bilinear_mip_texel_sampler_assert.svh @@
// ----------------------------------------------------------------------------
// Texel sampler assertion macros
// Shorthand for the clocked, reset-qualified checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_MIP_TEXEL_SAMPLER_ASSERT_SVH
`define BILINEAR_MIP_TEXEL_SAMPLER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define BMTS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("sampler check failed");

// Checks that an antecedent implies a consequent.
`define BMTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sampler implication failed");

`endif

@@ src/bmts_pkg.sv @@
// ----------------------------------------------------------------------------
// Texel sampler package
// Default sizes, operation codes and register indexes.
// ----------------------------------------------------------------------------
package bmts_pkg;

    localparam int TEXEL_DEPTH_DEF = 131072;
    localparam int MIP_LEVELS_DEF  = 8;
    localparam int FRAC_BITS_DEF   = 8;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        REG_WIDTH_LOG2  = 2'd0,
        REG_HEIGHT_LOG2 = 2'd1,
        REG_LEVEL_COUNT = 2'd2
    } reg_index_t;

endpackage

@@ src/bmts_texel_bank.sv @@
// ----------------------------------------------------------------------------
// Texel bank
// One write port and two registered read ports over a bank of texels.
// ----------------------------------------------------------------------------
module bmts_texel_bank #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic [AW-1:0] rd_addr0,
    input  logic [AW-1:0] rd_addr1,
    output logic [23:0]   rd_data0,
    output logic [23:0]   rd_data1
);

    logic [23:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

@@ src/bilinear_mip_texel_sampler.sv @@
// ----------------------------------------------------------------------------
// Bilinear mip texel sampler
// Texel store in two address-interleaved banks with a bilinear, shaded sampler.
// ----------------------------------------------------------------------------
//  channel  ports        word
//  input    s_axis       write texel or sample request
//  output   m_axis       filtered pixel and level
//  config   apb          width_log2, height_log2, level_count
//
// One word is taken every cycle while the output register is not stalled; a sample result passes through stages A to E.
// Both texel banks have two read ports, so all four neighbors are fetched at once.
// Reset clears the pipeline valid bits and sets the registers to their defaults; texels are not cleared.
// A full output register that is not taken stalls every stage.
module bilinear_mip_texel_sampler
    import bmts_pkg::*;
#(
    parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
    parameter int MIP_LEVELS  = MIP_LEVELS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[16:0], color[40:17], coord_u[56:41], coord_v[72:57],
    // step_u[80:73], shade[88:81], pixel_enable[89], zero[95:90]
    input  logic [95:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_color[23:0], mip_level[26:24], zero[31:27]
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(TEXEL_DEPTH);
    localparam int FA     = (AW > 18) ? AW + 1 : 19;
    localparam int BDEPTH = (TEXEL_DEPTH + 1) / 2;
    localparam int BW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int WTW    = FRAC_BITS + 1;
    localparam int HW     = FRAC_BITS + 8;
    localparam logic [FA-1:0] DEPTH_FA = FA'(TEXEL_DEPTH);

    // Configuration
    logic [3:0] wl_reg, hl_reg, lc_reg;
    logic [3:0] wl_c, hl_c, lc_c, lim_c;
    logic [2:0] lim_m1;
    logic [FA-1:0] base_reg [MIP_LEVELS];
    logic [FA-1:0] base_next [MIP_LEVELS];
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= 4'd8;
            hl_reg <= 4'd8;
            lc_reg <= 4'd1;
        end else if (cfg_wr) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_WIDTH_LOG2:  wl_reg <= pwdata[3:0];
                REG_HEIGHT_LOG2: hl_reg <= pwdata[3:0];
                REG_LEVEL_COUNT: lc_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index_t'(paddr[3:2]))
            REG_WIDTH_LOG2:  prdata = {28'd0, wl_reg};
            REG_HEIGHT_LOG2: prdata = {28'd0, hl_reg};
            REG_LEVEL_COUNT: prdata = {28'd0, lc_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        wl_c = (wl_reg < 4'd1) ? 4'd1 : ((wl_reg > 4'd8) ? 4'd8 : wl_reg);
        hl_c = (hl_reg < 4'd1) ? 4'd1 : ((hl_reg > 4'd8) ? 4'd8 : hl_reg);
        lc_c = (lc_reg < 4'd1) ? 4'd1 :
               ((lc_reg > 4'(MIP_LEVELS)) ? 4'(MIP_LEVELS) : lc_reg);
        lim_c = lc_c;
        if (wl_c < lim_c) lim_c = wl_c;
        if (hl_c < lim_c) lim_c = hl_c;
        lim_m1 = 3'(lim_c - 4'd1);
        base_next[0] = '0;
        for (int k = 1; k < MIP_LEVELS; k++) begin
            base_next[k] = base_next[k-1];
            if (4'(k) < lim_c) begin
                base_next[k] = base_next[k-1]
                             + (FA'(1) << (5'(wl_c) + 5'(hl_c) - 5'(2 * (k - 1))));
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MIP_LEVELS; k++) begin
            base_reg[k] <= base_next[k];
        end
    end

    // Pipeline advance
    logic m_valid_reg;
    logic adv;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Stage A: level choice and coordinate scaling
    logic [16:0] in_addr;
    logic [23:0] in_color;
    logic [15:0] in_cu, in_cv;
    logic [7:0]  in_step, in_shade;
    logic        in_en;
    logic [2:0]  lvl_raw, lvl;
    logic [15:0] cu_s, cv_s;
    logic [3:0]  wlog, hlog;
    logic [16:0] w_a, h_a, u_ext, v_ext;
    logic [7:0]  u_cl, v_cl;

    assign in_addr  = s_tdata[16:0];
    assign in_color = s_tdata[40:17];
    assign in_cu    = s_tdata[56:41];
    assign in_cv    = s_tdata[72:57];
    assign in_step  = s_tdata[80:73];
    assign in_shade = s_tdata[88:81];
    assign in_en    = s_tdata[89];

    always_comb begin
        lvl_raw = '0;
        for (int i = 1; i < 8; i++) begin
            if (in_step[i]) lvl_raw = 3'(i);
        end
        lvl   = (lvl_raw > lim_m1) ? lim_m1 : lvl_raw;
        cu_s  = in_cu >> lvl;
        cv_s  = in_cv >> lvl;
        wlog  = wl_c - 4'(lvl);
        hlog  = hl_c - 4'(lvl);
        w_a   = 17'd1 << wlog;
        h_a   = 17'd1 << hlog;
        u_ext = 17'(cu_s[15:FRAC_BITS]);
        v_ext = 17'(cv_s[15:FRAC_BITS]);
        u_cl  = (u_ext + 17'd1 >= w_a) ? 8'(w_a - 17'd2) : u_ext[7:0];
        v_cl  = (v_ext + 17'd1 >= h_a) ? 8'(h_a - 17'd2) : v_ext[7:0];
    end

    logic                 a_wr_reg, a_smp_reg;
    logic [16:0]          a_addr_reg;
    logic [23:0]          a_color_reg;
    logic [2:0]           a_lvl_reg;
    logic [3:0]           a_wlog_reg;
    logic [7:0]           a_u_reg, a_v_reg, a_shade_reg;
    logic [FRAC_BITS-1:0] a_fu_reg, a_fv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_wr_reg  <= 1'b0;
            a_smp_reg <= 1'b0;
        end else if (adv) begin
            a_wr_reg  <= s_tvalid && (s_tuser == OP_WRITE);
            a_smp_reg <= s_tvalid && (s_tuser == OP_SAMPLE) && in_en;
        end
        if (adv) begin
            a_addr_reg  <= in_addr;
            a_color_reg <= in_color;
            a_lvl_reg   <= lvl;
            a_wlog_reg  <= wlog;
            a_u_reg     <= u_cl;
            a_v_reg     <= v_cl;
            a_fu_reg    <= cu_s[FRAC_BITS-1:0];
            a_fv_reg    <= cv_s[FRAC_BITS-1:0];
            a_shade_reg <= in_shade;
        end
    end

    // Stage B: fetch addresses and texel bank access
    logic [FA-1:0] row0, row0p, row1, row1p, wr_fa;
    logic          odd;
    logic [BW-1:0] e_addr0, e_addr1, o_addr0, o_addr1, w_idx;
    logic          wr_ok, we_even, we_odd;

    always_comb begin
        row0  = base_reg[a_lvl_reg] + (FA'(a_v_reg) << a_wlog_reg) + FA'(a_u_reg);
        row0p = row0 + FA'(1);
        row1  = row0 + (FA'(1) << a_wlog_reg);
        row1p = row1 + FA'(1);
        odd   = row0[0];
        e_addr0 = odd ? row0p[BW:1] : row0[BW:1];
        o_addr0 = odd ? row0[BW:1]  : row0p[BW:1];
        e_addr1 = odd ? row1p[BW:1] : row1[BW:1];
        o_addr1 = odd ? row1[BW:1]  : row1p[BW:1];
        wr_fa   = FA'(a_addr_reg);
        wr_ok   = adv && a_wr_reg && (wr_fa < DEPTH_FA);
        w_idx   = wr_fa[BW:1];
        we_even = wr_ok && !wr_fa[0];
        we_odd  = wr_ok && wr_fa[0];
    end

    logic [23:0] e_d0, e_d1, o_d0, o_d1;

    bmts_texel_bank #(.DEPTH(BDEPTH), .AW(BW)) u_bank_even (
        .aclk     (aclk),
        .rd_en    (adv),
        .wr_en    (we_even),
        .wr_addr  (w_idx),
        .wr_data  (a_color_reg),
        .rd_addr0 (e_addr0),
        .rd_addr1 (e_addr1),
        .rd_data0 (e_d0),
        .rd_data1 (e_d1)
    );

    bmts_texel_bank #(.DEPTH(BDEPTH), .AW(BW)) u_bank_odd (
        .aclk     (aclk),
        .rd_en    (adv),
        .wr_en    (we_odd),
        .wr_addr  (w_idx),
        .wr_data  (a_color_reg),
        .rd_addr0 (o_addr0),
        .rd_addr1 (o_addr1),
        .rd_data0 (o_d0),
        .rd_data1 (o_d1)
    );

    logic                 b_smp_reg, b_odd_reg;
    logic [3:0]           b_ok_reg;
    logic [2:0]           b_lvl_reg;
    logic [7:0]           b_shade_reg;
    logic [FRAC_BITS-1:0] b_fu_reg, b_fv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_smp_reg <= 1'b0;
        end else if (adv) begin
            b_smp_reg <= a_smp_reg;
        end
        if (adv) begin
            b_odd_reg   <= odd;
            b_ok_reg    <= {row1p < DEPTH_FA, row1 < DEPTH_FA,
                            row0p < DEPTH_FA, row0 < DEPTH_FA};
            b_lvl_reg   <= a_lvl_reg;
            b_shade_reg <= a_shade_reg;
            b_fu_reg    <= a_fu_reg;
            b_fv_reg    <= a_fv_reg;
        end
    end

    // Stage C: horizontal blend
    logic [23:0]    t00, t01, t10, t11;
    logic [WTW-1:0] wx0, wx1;
    logic [HW-1:0]  h0 [3], h1 [3];

    always_comb begin
        t00 = b_ok_reg[0] ? (b_odd_reg ? o_d0 : e_d0) : 24'd0;
        t01 = b_ok_reg[1] ? (b_odd_reg ? e_d0 : o_d0) : 24'd0;
        t10 = b_ok_reg[2] ? (b_odd_reg ? o_d1 : e_d1) : 24'd0;
        t11 = b_ok_reg[3] ? (b_odd_reg ? e_d1 : o_d1) : 24'd0;
        wx1 = WTW'(b_fu_reg);
        wx0 = (WTW'(1) << FRAC_BITS) - wx1;
        for (int c = 0; c < 3; c++) begin
            h0[c] = HW'(t00[c*8 +: 8] * wx0) + HW'(t01[c*8 +: 8] * wx1);
            h1[c] = HW'(t10[c*8 +: 8] * wx0) + HW'(t11[c*8 +: 8] * wx1);
        end
    end

    logic                 c_smp_reg;
    logic [HW-1:0]        c_h0_reg [3], c_h1_reg [3];
    logic [2:0]           c_lvl_reg;
    logic [7:0]           c_shade_reg;
    logic [FRAC_BITS-1:0] c_fv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_smp_reg <= 1'b0;
        end else if (adv) begin
            c_smp_reg <= b_smp_reg;
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                c_h0_reg[c] <= h0[c];
                c_h1_reg[c] <= h1[c];
            end
            c_lvl_reg   <= b_lvl_reg;
            c_shade_reg <= b_shade_reg;
            c_fv_reg    <= b_fv_reg;
        end
    end

    // Stage D: vertical blend
    logic [WTW-1:0]  wy0, wy1;
    logic [HW+WTW:0] vsum [3];

    always_comb begin
        wy1 = WTW'(c_fv_reg);
        wy0 = (WTW'(1) << FRAC_BITS) - wy1;
        for (int c = 0; c < 3; c++) begin
            vsum[c] = (HW+WTW+1)'(c_h0_reg[c] * wy0) + (HW+WTW+1)'(c_h1_reg[c] * wy1);
        end
    end

    logic       d_smp_reg;
    logic [7:0] d_ch_reg [3];
    logic [2:0] d_lvl_reg;
    logic [7:0] d_shade_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_smp_reg <= 1'b0;
        end else if (adv) begin
            d_smp_reg <= c_smp_reg;
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                d_ch_reg[c] <= vsum[c][2*FRAC_BITS +: 8];
            end
            d_lvl_reg   <= c_lvl_reg;
            d_shade_reg <= c_shade_reg;
        end
    end

    // Stage E: shading into the output register
    logic [15:0] shaded [3];
    logic [23:0] pix_next;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shaded[c] = d_ch_reg[c] * d_shade_reg;
        end
        pix_next = {shaded[2][15:8], shaded[1][15:8], shaded[0][15:8]};
    end

    logic [23:0] m_pix_reg;
    logic [2:0]  m_lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_smp_reg;
        end
        if (adv) begin
            m_pix_reg <= pix_next;
            m_lvl_reg <= d_lvl_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_lvl_reg, m_pix_reg};

    `include "bilinear_mip_texel_sampler_assert.svh"

    `BMTS_ASSERT_IMP(a_stall_holds, m_tvalid && !m_tready, !s_tready)
    `BMTS_ASSERT_IMP(a_level_in_range, m_tvalid, m_lvl_reg <= lim_m1)
    `BMTS_ASSERT(a_one_kind, !(a_wr_reg && a_smp_reg))

endmodule
